// ===== hw/rtl/tlptq_pkg.sv =====
// Shared types and codes for the three-level priority task queue.
`default_nettype none

package tlptq_pkg;

  // Operation codes carried on in_tuser.
  localparam logic [2:0] OP_APPEND     = 3'd0;
  localparam logic [2:0] OP_POP        = 3'd1;
  localparam logic [2:0] OP_PEEK       = 3'd2;
  localparam logic [2:0] OP_CANCEL_TAG = 3'd3;
  localparam logic [2:0] OP_CANCEL_ID  = 3'd4;

  // Result status codes carried on out_tuser.
  localparam logic [1:0] ST_DONE     = 2'd0;
  localparam logic [1:0] ST_NOTFOUND = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;

  localparam int TAG_W   = 8;
  localparam int ID_W    = 32;
  localparam int OUT_LVL_W = 2;

  typedef struct packed {
    logic [TAG_W-1:0] tag;
    logic [ID_W-1:0]  id;
  } entry_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_APPEND,
    S_FIND,
    S_PEMIT,
    S_CSCAN,
    S_CCHK,
    S_CFIN
  } state_t;

endpackage

`default_nettype wire

// ===== hw/rtl/three_level_priority_task_queue_top.sv =====
// Top level of the strict-priority multi-level task queue with cancel.
`default_nettype none

// Keeps NUM_LEVELS circular FIFOs of tasks (8-bit tag, 32-bit group id) in one
// single-port-write, single-port-read memory, with level 0 served first. One
// transaction is worked on at a time and in_tready is low until its last
// result has been placed in the output register. Pop and peek pass over each
// empty level in turn and report not found when every level is empty. Cancel
// by id walks every stored entry through the one memory read port and compacts
// the survivors through the one write port; cancel by handle stops after the
// level that holds its match. Either reads and checks each entry walked in
// turn. A result waits in the output register while the next one is being
// found; a stalled output holds the sequencer.
module three_level_priority_task_queue_top #(
  parameter int QUEUE_DEPTH = 16,
  parameter int NUM_LEVELS  = 3
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [47:0] in_tdata,  // level[1:0], task_tag[9:2], task_id[41:10], zeros
  input  wire logic [2:0]  in_tuser,  // operation[2:0]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [47:0]      out_tdata, // out_tag[7:0], out_id[39:8], out_level[41:40], zeros
  output logic [1:0]       out_tuser, // status[1:0]
  output logic             out_tlast
);

  localparam int IW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int LW = (NUM_LEVELS > 1) ? $clog2(NUM_LEVELS) : 1;
  localparam int NE = NUM_LEVELS * QUEUE_DEPTH;
  localparam int AW = $clog2(NE);
  localparam int OLW = tlptq_pkg::OUT_LVL_W;

  // Input fields.
  logic [1:0]  in_level;
  logic [7:0]  in_tag;
  logic [31:0] in_id;
  assign in_level = in_tdata[1:0];
  assign in_tag   = in_tdata[9:2];
  assign in_id    = in_tdata[41:10];

  tlptq_pkg::state_t state_r, state_nxt;
  logic [2:0]    op_r, op_nxt;
  logic [7:0]    tag_r, tag_nxt;
  logic [31:0]   id_r, id_nxt;
  logic [LW-1:0] lvl_r, lvl_nxt;
  logic [CW-1:0] rd_off_r, rd_off_nxt;
  logic [CW-1:0] wr_off_r, wr_off_nxt;
  logic          found_r, found_nxt;
  tlptq_pkg::entry_t pend_r, pend_nxt;
  logic [LW-1:0] pend_lvl_r, pend_lvl_nxt;

  logic [CW-1:0] cnt_r  [NUM_LEVELS];
  logic [CW-1:0] cnt_nxt[NUM_LEVELS];
  logic [IW-1:0] head_r  [NUM_LEVELS];
  logic [IW-1:0] head_nxt[NUM_LEVELS];

  logic          out_valid_r, out_valid_nxt;
  logic [1:0]    out_status_r, out_status_nxt;
  logic [7:0]    out_tag_r, out_tag_nxt;
  logic [31:0]   out_id_r, out_id_nxt;
  logic [1:0]    out_level_r, out_level_nxt;
  logic          out_last_r, out_last_nxt;

  // Task memory.
  tlptq_pkg::entry_t mem [NE];
  tlptq_pkg::entry_t rd_data_r;
  logic [AW-1:0]     rd_addr, wr_addr;
  logic              wr_en;
  tlptq_pkg::entry_t wr_data;

  logic [CW-1:0] cnt_cur;
  logic [IW-1:0] head_cur;
  logic [IW:0]   rd_sum, wr_sum;
  logic [IW-1:0] rd_phys, wr_phys;
  logic [CW-1:0] wr_sel;
  logic          out_free;
  logic          lvl_last;
  logic          in_clamp;
  logic          is_match;

  assign cnt_cur  = cnt_r[lvl_r];
  assign head_cur = head_r[lvl_r];
  assign out_free = !out_valid_r || out_tready;
  assign lvl_last = (32'(lvl_r) == 32'(NUM_LEVELS - 1));
  assign in_clamp = (32'(in_level) >= 32'(NUM_LEVELS));

  // Offsets from the head wrap around the circular buffer of the level.
  assign wr_sel  = (state_r == tlptq_pkg::S_APPEND) ? cnt_cur : wr_off_r;
  assign rd_sum  = {1'b0, head_cur} + (IW+1)'(rd_off_r[IW-1:0]);
  assign wr_sum  = {1'b0, head_cur} + (IW+1)'(wr_sel[IW-1:0]);
  assign rd_phys = (32'(rd_sum) >= 32'(QUEUE_DEPTH)) ?
                   IW'(32'(rd_sum) - 32'(QUEUE_DEPTH)) : rd_sum[IW-1:0];
  assign wr_phys = (32'(wr_sum) >= 32'(QUEUE_DEPTH)) ?
                   IW'(32'(wr_sum) - 32'(QUEUE_DEPTH)) : wr_sum[IW-1:0];
  assign rd_addr = AW'(32'(lvl_r) * QUEUE_DEPTH + 32'(rd_phys));
  assign wr_addr = AW'(32'(lvl_r) * QUEUE_DEPTH + 32'(wr_phys));

  assign is_match = ((op_r == tlptq_pkg::OP_CANCEL_TAG) && !found_r &&
                     (rd_data_r.tag == tag_r)) ||
                    ((op_r == tlptq_pkg::OP_CANCEL_ID) && (rd_data_r.id == id_r));

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  always_comb begin
    state_nxt      = state_r;
    op_nxt         = op_r;
    tag_nxt        = tag_r;
    id_nxt         = id_r;
    lvl_nxt        = lvl_r;
    rd_off_nxt     = rd_off_r;
    wr_off_nxt     = wr_off_r;
    found_nxt      = found_r;
    pend_nxt       = pend_r;
    pend_lvl_nxt   = pend_lvl_r;
    cnt_nxt        = cnt_r;
    head_nxt       = head_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_status_nxt = out_status_r;
    out_tag_nxt    = out_tag_r;
    out_id_nxt     = out_id_r;
    out_level_nxt  = out_level_r;
    out_last_nxt   = out_last_r;
    wr_en          = 1'b0;
    wr_data        = '{tag: tag_r, id: id_r};
    in_tready      = 1'b0;

    case (state_r)
      tlptq_pkg::S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          op_nxt     = in_tuser;
          tag_nxt    = in_tag;
          id_nxt     = in_id;
          rd_off_nxt = '0;
          wr_off_nxt = '0;
          found_nxt  = 1'b0;
          lvl_nxt    = '0;
          case (in_tuser)
            tlptq_pkg::OP_APPEND: begin
              lvl_nxt   = in_clamp ? LW'(NUM_LEVELS - 1) : LW'(in_level);
              state_nxt = tlptq_pkg::S_APPEND;
            end
            tlptq_pkg::OP_POP,
            tlptq_pkg::OP_PEEK:       state_nxt = tlptq_pkg::S_FIND;
            tlptq_pkg::OP_CANCEL_TAG,
            tlptq_pkg::OP_CANCEL_ID:  state_nxt = tlptq_pkg::S_CSCAN;
            default:                  state_nxt = tlptq_pkg::S_IDLE;
          endcase
        end
      end

      tlptq_pkg::S_APPEND: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_tag_nxt   = tag_r;
          out_id_nxt    = id_r;
          out_level_nxt = OLW'(lvl_r);
          out_last_nxt  = 1'b1;
          if (32'(cnt_cur) >= 32'(QUEUE_DEPTH)) begin
            out_status_nxt = tlptq_pkg::ST_FULL;
          end else begin
            out_status_nxt = tlptq_pkg::ST_DONE;
            wr_en          = 1'b1;
            cnt_nxt[lvl_r] = cnt_cur + CW'(1);
          end
          state_nxt = tlptq_pkg::S_IDLE;
        end
      end

      // The read of the front entry is issued here; its data is ready next cycle.
      tlptq_pkg::S_FIND: begin
        if (cnt_cur != '0) begin
          state_nxt = tlptq_pkg::S_PEMIT;
        end else if (lvl_last) begin
          if (out_free) begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = tlptq_pkg::ST_NOTFOUND;
            out_tag_nxt    = '0;
            out_id_nxt     = '0;
            out_level_nxt  = '0;
            out_last_nxt   = 1'b1;
            state_nxt      = tlptq_pkg::S_IDLE;
          end
        end else begin
          lvl_nxt = lvl_r + LW'(1);
        end
      end

      tlptq_pkg::S_PEMIT: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = tlptq_pkg::ST_DONE;
          out_tag_nxt    = rd_data_r.tag;
          out_id_nxt     = rd_data_r.id;
          out_level_nxt  = OLW'(lvl_r);
          out_last_nxt   = 1'b1;
          if (op_r == tlptq_pkg::OP_POP) begin
            head_nxt[lvl_r] = (32'(head_cur) == 32'(QUEUE_DEPTH - 1)) ?
                              '0 : head_cur + IW'(1);
            cnt_nxt[lvl_r]  = cnt_cur - CW'(1);
          end
          state_nxt = tlptq_pkg::S_IDLE;
        end
      end

      // Walk one level; survivors are copied down to the write offset.
      tlptq_pkg::S_CSCAN: begin
        if (rd_off_r == cnt_cur) begin
          cnt_nxt[lvl_r] = wr_off_r;
          if (lvl_last || ((op_r == tlptq_pkg::OP_CANCEL_TAG) && found_r)) begin
            state_nxt = tlptq_pkg::S_CFIN;
          end else begin
            lvl_nxt    = lvl_r + LW'(1);
            rd_off_nxt = '0;
            wr_off_nxt = '0;
          end
        end else begin
          state_nxt = tlptq_pkg::S_CCHK;
        end
      end

      // A match becomes the pending result; the one it replaces is sent as not last.
      tlptq_pkg::S_CCHK: begin
        if (is_match) begin
          if (!found_r || out_free) begin
            if (found_r) begin
              out_valid_nxt  = 1'b1;
              out_status_nxt = tlptq_pkg::ST_DONE;
              out_tag_nxt    = pend_r.tag;
              out_id_nxt     = pend_r.id;
              out_level_nxt  = OLW'(pend_lvl_r);
              out_last_nxt   = 1'b0;
            end
            found_nxt    = 1'b1;
            pend_nxt     = rd_data_r;
            pend_lvl_nxt = lvl_r;
            rd_off_nxt   = rd_off_r + CW'(1);
            state_nxt    = tlptq_pkg::S_CSCAN;
          end
        end else begin
          wr_en      = 1'b1;
          wr_data    = rd_data_r;
          wr_off_nxt = wr_off_r + CW'(1);
          rd_off_nxt = rd_off_r + CW'(1);
          state_nxt  = tlptq_pkg::S_CSCAN;
        end
      end

      tlptq_pkg::S_CFIN: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_last_nxt  = 1'b1;
          if (found_r) begin
            out_status_nxt = tlptq_pkg::ST_DONE;
            out_tag_nxt    = pend_r.tag;
            out_id_nxt     = pend_r.id;
            out_level_nxt  = OLW'(pend_lvl_r);
          end else begin
            out_status_nxt = tlptq_pkg::ST_NOTFOUND;
            out_tag_nxt    = '0;
            out_id_nxt     = '0;
            out_level_nxt  = '0;
          end
          state_nxt = tlptq_pkg::S_IDLE;
        end
      end

      default: state_nxt = tlptq_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tlptq_pkg::S_IDLE;
      out_valid_r <= 1'b0;
      found_r     <= 1'b0;
      for (int i = 0; i < NUM_LEVELS; i++) begin
        cnt_r[i]  <= '0;
        head_r[i] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      found_r     <= found_nxt;
      cnt_r       <= cnt_nxt;
      head_r      <= head_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    tag_r        <= tag_nxt;
    id_r         <= id_nxt;
    lvl_r        <= lvl_nxt;
    rd_off_r     <= rd_off_nxt;
    wr_off_r     <= wr_off_nxt;
    pend_r       <= pend_nxt;
    pend_lvl_r   <= pend_lvl_nxt;
    out_status_r <= out_status_nxt;
    out_tag_r    <= out_tag_nxt;
    out_id_r     <= out_id_nxt;
    out_level_r  <= out_level_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, out_level_r, out_id_r, out_tag_r};
  assign out_tuser  = out_status_r;
  assign out_tlast  = out_last_r;

endmodule

`default_nettype wire
